FILE: hdl/acars_frame_checker_defines.svh
// Assertion macros used by the checker file acf_checker.sv.
`ifndef ACARS_FRAME_CHECKER_DEFINES_SVH
`define ACARS_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define ACF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define ACF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/acf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acf_pkg;

    // Byte codes of the frame layout
    localparam logic [7:0] MARKER_SOH = 8'h01;
    localparam logic [7:0] SUFFIX_DEL = 8'h7F;
    localparam logic [7:0] HEADER_ETX = 8'h03;

    // CRC-16/Kermit, reflected polynomial
    localparam logic [15:0] CRC_POLY = 16'h8408;

    localparam int HDR_LEN      = 8;
    localparam int MIN_BODY     = 13;
    localparam int CK_LEN       = 3;    // two CRC bytes plus the suffix
    localparam int CK_CRC_BYTES = 2;
    localparam int BODY_LEN_MAX = 1023;

    // Frame verdict codes
    localparam logic [2:0] ST_NOT_ACARS  = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
    localparam logic [2:0] ST_ACCEPTED   = 3'd2;
    localparam logic [2:0] ST_SUPPRESSED = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;

    // Configuration space: one 32-bit register per word
    localparam int         PADDR_W          = 3;
    localparam logic [0:0] REG_DROP_ERRORED = 1'b0;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       end_of_frame;
    } acf_in_t;

    typedef struct packed {
        logic [2:0] frame_status;
        logic       crc_error;
        logic       parity_error;
        logic [1:0] error_count;
        logic       has_checksum;
        logic       has_header;
        logic [9:0] body_length;
    } acf_out_t;

    // One byte through the reflected CRC, eight shift steps
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic odd_parity(input logic [7:0] b);
        return ^b;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/acars_frame_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// byte      in         byte_valid/byte_stall   payload_byte, end_of_frame
// verdict   out        verdict_valid/_stall    frame_status .. body_length
// apb       in/out     psel/penable/pready     drop_errored at byte address 0
//
// One byte per cycle unless a stalled verdict holds an end byte: each ordinary
// byte lands in the input register and is folded into the frame state (two
// CRC-16/Kermit byte steps, parity) on the next edge. The end byte's verdict
// loads into the result register as the byte leaves the input register. Reset
// clears the frame state and drop_errored; after every end byte the frame
// state returns to its reset value. A stalled verdict holds the end byte of
// the next frame in the input register; ordinary bytes keep flowing.

module acars_frame_checker #(
    parameter int MAX_BODY = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // byte channel
    input  wire logic                        byte_valid,
    output logic                             byte_stall,
    input  wire acf_pkg::acf_in_t            byte_data,
    // verdict channel
    output logic                             verdict_valid,
    input  wire logic                        verdict_stall,
    output acf_pkg::acf_out_t                verdict_data,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [acf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import acf_pkg::*;

    logic     drop_errored_reg;
    logic     cfg_write;
    logic     item_valid;
    acf_in_t  item_data;
    logic     item_take;
    logic     out_ready;
    logic     verdict_load;
    acf_out_t verdict;

    // Configuration: zero-wait APB, written on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[PADDR_W-1:2] == REG_DROP_ERRORED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            drop_errored_reg <= 1'b0;
        end
        else if (cfg_write) begin
            drop_errored_reg <= pwdata[0];
        end
    end

    // Read back the register; other words read as zero
    assign prdata = (paddr[PADDR_W-1:2] == REG_DROP_ERRORED) ? {31'b0, drop_errored_reg}
                                                             : 32'b0;

    // Input register: takes a transfer whenever it is empty or empties this cycle
    acf_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .item_valid (item_valid),
        .item_data  (item_data),
        .item_take  (item_take)
    );

    // Frame state and verdict logic
    acf_eval #(
        .MAX_BODY (MAX_BODY)
    ) u_eval (
        .clk          (clk),
        .rst_n        (rst_n),
        .drop_errored (drop_errored_reg),
        .item_valid   (item_valid),
        .item_data    (item_data),
        .item_take    (item_take),
        .out_ready    (out_ready),
        .verdict_load (verdict_load),
        .verdict      (verdict)
    );

    // Result register: holds the verdict until the transfer completes
    acf_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .verdict_load  (verdict_load),
        .verdict       (verdict),
        .out_ready     (out_ready),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict_data  (verdict_data)
    );

endmodule

`default_nettype wire

FILE: hdl/acf_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module acf_in_reg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            byte_valid,
    output logic                 byte_stall,
    input  wire acf_pkg::acf_in_t byte_data,
    output logic                 item_valid,
    output acf_pkg::acf_in_t     item_data,
    input  wire logic            item_take
);
    import acf_pkg::*;

    logic    valid_reg, valid_next;
    acf_in_t data_reg;
    logic    load;

    // Hold the byte while the evaluation stage cannot take it
    assign byte_stall = valid_reg && !item_take;
    assign load       = byte_valid && !byte_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end
        else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            data_reg <= byte_data;
        end
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;

endmodule

`default_nettype wire

FILE: hdl/acf_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module acf_eval #(
    parameter int MAX_BODY = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             drop_errored,
    input  wire logic             item_valid,
    input  wire acf_pkg::acf_in_t item_data,
    output logic                  item_take,
    input  wire logic             out_ready,
    output logic                  verdict_load,
    output acf_pkg::acf_out_t     verdict
);
    import acf_pkg::*;

    localparam int POS_CAP = MAX_BODY + 16;
    localparam int POS_W   = $clog2(POS_CAP + 1);
    localparam int EXT_W   = ((POS_W > 10) ? POS_W : 10) + 2;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       tw0_reg, tw1_reg, tw2_reg;
    logic [15:0]      crc_nh_reg, crc_nh_next;
    logic [15:0]      crc_wh_reg, crc_wh_next;
    logic             ph_reg, ph_next;
    logic             pr_reg, pr_next;
    logic [7:0]       fb_reg, fb_next;
    logic             marker_reg, marker_next;

    logic             advance;
    logic [7:0]       b;
    logic             eof;

    // Frame updates for the byte now leaving the input register
    always_comb
    begin
        b           = item_data.payload_byte;
        eof         = item_data.end_of_frame;
        crc_wh_next = crc_wh_reg;
        crc_nh_next = crc_nh_reg;
        ph_next     = ph_reg;
        pr_next     = pr_reg;
        fb_next     = fb_reg;
        marker_next = marker_reg;

        if (pos_reg == '0) begin
            marker_next = (b == MARKER_SOH);
        end
        else begin
            if (pos_reg >= POS_W'(2)) begin
                crc_wh_next = crc_step(crc_wh_reg, tw0_reg);
            end
            if (pos_reg >= POS_W'(HDR_LEN + 2)) begin
                crc_nh_next = crc_step(crc_nh_reg, tw0_reg);
            end
            // the byte three back is known not to be a CRC byte
            if (pos_reg >= POS_W'(4)) begin
                if (pos_reg < POS_W'(HDR_LEN + 4)) begin
                    ph_next = ph_reg & odd_parity(tw2_reg);
                end
                else begin
                    pr_next = pr_reg & odd_parity(tw2_reg);
                end
            end
            if (pos_reg == POS_W'(1)) begin
                fb_next = b;
            end
        end
        pos_next = (pos_reg < POS_W'(POS_CAP)) ? pos_reg + POS_W'(1) : pos_reg;
    end

    logic             ck, hdr, ph_f, pr_f, ce, pe;
    logic [POS_W-1:0] nb, blen;
    logic [EXT_W-1:0] blen_x, span_x;
    logic [15:0]      crc_sel;

    // End-of-frame verdict
    always_comb
    begin
        ck      = (pos_reg >= POS_W'(CK_LEN)) && (b == SUFFIX_DEL);
        nb      = ck ? pos_reg - POS_W'(CK_LEN) : pos_reg;
        hdr     = (nb >= POS_W'(HDR_LEN)) && (fb_next == HEADER_ETX);
        blen    = nb - (hdr ? POS_W'(HDR_LEN) : '0);
        blen_x  = EXT_W'(blen);
        span_x  = blen_x + (ck ? EXT_W'(CK_CRC_BYTES) : '0);
        crc_sel = hdr ? crc_nh_next : crc_wh_next;
        ph_f    = ph_next;
        pr_f    = pr_next;

        if (ck) begin
            ce = (crc_sel != '0);
        end
        else begin
            ce = 1'b1;
            // fold in the last three bytes, which were never CRC bytes
            if (pos_reg >= POS_W'(1)) begin
                if (pos_reg <= POS_W'(HDR_LEN)) begin
                    ph_f = ph_f & odd_parity(b);
                end
                else begin
                    pr_f = pr_f & odd_parity(b);
                end
            end
            if (pos_reg >= POS_W'(2)) begin
                if (pos_reg <= POS_W'(HDR_LEN + 1)) begin
                    ph_f = ph_f & odd_parity(tw0_reg);
                end
                else begin
                    pr_f = pr_f & odd_parity(tw0_reg);
                end
            end
            if (pos_reg >= POS_W'(3)) begin
                if (pos_reg <= POS_W'(HDR_LEN + 2)) begin
                    ph_f = ph_f & odd_parity(tw1_reg);
                end
                else begin
                    pr_f = pr_f & odd_parity(tw1_reg);
                end
            end
        end
        pe = !(pr_f && (hdr || ph_f));

        verdict = '0;
        if (!marker_next) begin
            verdict.frame_status = ST_NOT_ACARS;
        end
        else if (pos_reg <= POS_W'(1)) begin
            verdict.frame_status = ST_TOO_SHORT;
        end
        else begin
            verdict.crc_error    = ce;
            verdict.parity_error = pe;
            verdict.error_count  = {1'b0, ce} + {1'b0, pe};
            verdict.has_checksum = ck;
            verdict.has_header   = hdr;
            verdict.body_length  = (blen_x > EXT_W'(BODY_LEN_MAX)) ? 10'(BODY_LEN_MAX)
                                                                   : blen_x[9:0];
            if (span_x > EXT_W'(MAX_BODY)) begin
                verdict.frame_status = ST_TOO_LONG;
            end
            else if (blen_x < EXT_W'(MIN_BODY)) begin
                verdict.frame_status = ST_TOO_SHORT;
            end
            else if (drop_errored && (ce || pe)) begin
                verdict.frame_status = ST_SUPPRESSED;
            end
            else begin
                verdict.frame_status = ST_ACCEPTED;
            end
        end
    end

    // An end byte moves only when the result register can take its verdict
    assign advance      = item_valid && (!eof || out_ready);
    assign item_take    = advance;
    assign verdict_load = advance && eof;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg    <= '0;
            tw0_reg    <= '0;
            tw1_reg    <= '0;
            tw2_reg    <= '0;
            crc_nh_reg <= '0;
            crc_wh_reg <= '0;
            ph_reg     <= 1'b1;
            pr_reg     <= 1'b1;
            fb_reg     <= '0;
            marker_reg <= 1'b0;
        end
        else if (advance) begin
            if (eof) begin
                pos_reg    <= '0;
                tw0_reg    <= '0;
                tw1_reg    <= '0;
                tw2_reg    <= '0;
                crc_nh_reg <= '0;
                crc_wh_reg <= '0;
                ph_reg     <= 1'b1;
                pr_reg     <= 1'b1;
                fb_reg     <= '0;
                marker_reg <= 1'b0;
            end
            else begin
                pos_reg    <= pos_next;
                tw0_reg    <= b;
                tw1_reg    <= tw0_reg;
                tw2_reg    <= tw1_reg;
                crc_nh_reg <= crc_nh_next;
                crc_wh_reg <= crc_wh_next;
                ph_reg     <= ph_next;
                pr_reg     <= pr_next;
                fb_reg     <= fb_next;
                marker_reg <= marker_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/acf_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module acf_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              verdict_load,
    input  wire acf_pkg::acf_out_t verdict,
    output logic                   out_ready,
    output logic                   verdict_valid,
    input  wire logic              verdict_stall,
    output acf_pkg::acf_out_t      verdict_data
);
    import acf_pkg::*;

    logic     valid_reg, valid_next;
    acf_out_t data_reg;

    // Free when empty or when the held verdict leaves this cycle
    assign out_ready = !valid_reg || !verdict_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (verdict_load) begin
            valid_next = 1'b1;
        end
        else if (!verdict_stall) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (verdict_load) begin
            data_reg <= verdict;
        end
    end

    assign verdict_valid = valid_reg;
    assign verdict_data  = data_reg;

endmodule

`default_nettype wire

FILE: hdl/acf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "acars_frame_checker_defines.svh"

module acf_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              byte_valid,
    input wire logic              byte_stall,
    input wire logic              verdict_valid,
    input wire logic              verdict_stall,
    input wire acf_pkg::acf_out_t verdict_data
);
    import acf_pkg::*;

    logic [1:0] err_sum;

    assign err_sum = {1'b0, verdict_data.crc_error} + {1'b0, verdict_data.parity_error};

    // The input only stalls while a byte it took is still held
    `ACF_ASSERT_NOW(a_stall_after_transfer, clk, rst_n,
        $rose(byte_stall),
        $past(byte_valid),
        "byte_stall rose without a preceding transfer")

    // A stalled verdict stays put
    `ACF_ASSERT_NEXT(a_verdict_hold, clk, rst_n,
        verdict_valid && verdict_stall,
        verdict_valid && $stable(verdict_data),
        "verdict changed while stalled")

    `ACF_ASSERT_NOW(a_error_sum, clk, rst_n,
        verdict_valid,
        verdict_data.error_count == err_sum,
        "error_count does not match the error flags")

    // A frame without the marker carries no other information
    `ACF_ASSERT_NOW(a_not_acars_clear, clk, rst_n,
        verdict_valid && (verdict_data.frame_status == ST_NOT_ACARS),
        (verdict_data.error_count == 2'd0) && !verdict_data.has_checksum
            && !verdict_data.has_header && (verdict_data.body_length == 10'd0),
        "rejected frame carries fields")

    // Suppression only ever hides an errored frame of sane length
    `ACF_ASSERT_NOW(a_suppress_errored, clk, rst_n,
        verdict_valid && (verdict_data.frame_status == ST_SUPPRESSED),
        (verdict_data.error_count != 2'd0) && (verdict_data.body_length >= 10'(MIN_BODY)),
        "suppressed frame without errors or too short")

endmodule

bind acars_frame_checker acf_checker u_acf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict_data  (verdict_data)
);

`default_nettype wire

FILE: tb/acars_frame_checker_test.sv
`timescale 1ns / 1ps

module acars_frame_checker_test;

    import acf_pkg::*;

    localparam int BODY_CAP    = 1024;
    localparam int POS_CAP     = BODY_CAP + 16;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;
    localparam logic [PADDR_W-1:0] DROP_ADDR = PADDR_W'(4 * REG_DROP_ERRORED);

    // Verdicts that can be read straight off the frame layout
    localparam acf_out_t NO_VERDICT        = '0;
    localparam acf_out_t NOT_ACARS_VERDICT = '{frame_status: ST_NOT_ACARS, default: '0};
    localparam acf_out_t TOO_SHORT_VERDICT = '{frame_status: ST_TOO_SHORT, default: '0};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fixed;     // use want below rather than the running model
        acf_out_t   want;
    } directed_row_t;

    // Opening stimulus: missing marker, one- and two-byte payloads, a marker
    // that only turns up second, a three-byte payload ending in the suffix
    // byte without room for a checksum, and a minimum-length body.
    localparam directed_row_t DIRECTED_ROWS [24] = '{
        '{8'h00, 1'b1, 1'b1, NOT_ACARS_VERDICT},
        '{8'h01, 1'b1, 1'b1, TOO_SHORT_VERDICT},
        '{8'h01, 1'b0, 1'b0, NO_VERDICT},
        '{8'hFF, 1'b1, 1'b1, TOO_SHORT_VERDICT},
        '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
        '{8'h01, 1'b0, 1'b0, NO_VERDICT},
        '{8'h7F, 1'b1, 1'b1, NOT_ACARS_VERDICT},
        '{8'h01, 1'b0, 1'b0, NO_VERDICT},
        '{8'h80, 1'b0, 1'b0, NO_VERDICT},
        '{8'h7F, 1'b1, 1'b0, NO_VERDICT},
        '{8'h01, 1'b0, 1'b0, NO_VERDICT},
        '{8'h80, 1'b0, 1'b0, NO_VERDICT},
        '{8'h01, 1'b0, 1'b0, NO_VERDICT},
        '{8'h02, 1'b0, 1'b0, NO_VERDICT},
        '{8'h04, 1'b0, 1'b0, NO_VERDICT},
        '{8'h08, 1'b0, 1'b0, NO_VERDICT},
        '{8'h10, 1'b0, 1'b0, NO_VERDICT},
        '{8'h20, 1'b0, 1'b0, NO_VERDICT},
        '{8'h40, 1'b0, 1'b0, NO_VERDICT},
        '{8'hFE, 1'b0, 1'b0, NO_VERDICT},
        '{8'hFD, 1'b0, 1'b0, NO_VERDICT},
        '{8'hFB, 1'b0, 1'b0, NO_VERDICT},
        '{8'hF7, 1'b0, 1'b0, NO_VERDICT},
        '{8'hEF, 1'b1, 1'b0, NO_VERDICT}
    };

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 byte_valid    = 1'b0;
    logic                 byte_stall;
    acf_in_t              byte_data     = '0;
    logic                 verdict_valid;
    logic                 verdict_stall = 1'b0;
    acf_out_t             verdict_data;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [31:0]          pwdata        = '0;
    logic [31:0]          prdata;
    logic                 pready;

    acars_frame_checker #(
        .MAX_BODY(BODY_CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .verdict_valid(verdict_valid),
        .verdict_stall(verdict_stall),
        .verdict_data (verdict_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Expected verdicts, oldest first, and the mismatch tally
    acf_out_t    verdicts_due[$];
    int          mismatch_count = 0;

    // Coordination between the byte sender and the verdict receiver
    bit          calm          = 1'b0;   // final stretch: no idling on either side
    bit          hold_req      = 1'b0;   // ask the receiver for one long hold-off
    bit          frame_gappy   = 1'b1;   // idle bursts allowed within this frame
    int          bytes_sent    = 0;

    // Running frame state of the checker as the testbench sees it
    bit          drop_shadow   = 1'b0;
    logic [7:0]  recent [3];
    int unsigned seen_count;
    logic [15:0] crc_all;                 // from body byte 0
    logic [15:0] crc_body;                // from body byte 8, past any header
    bit          ok_lead;                 // parity of body bytes 0..7
    bit          ok_tail;                 // parity of body bytes 8 onwards
    logic [7:0]  lead_byte;
    bit          soh_ok;

    logic [7:0]  frame_buf[$];

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog: far beyond the slowest legal run, holds included
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Reflected CRC-16, one data bit at a time, least significant first
    function automatic logic [15:0] kermit_fold(input logic [15:0] c, input logic [7:0] d);
        logic fb;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ d[k];
            c  = c >> 1;
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic clear_frame_state();
        recent     = '{default: 8'h00};
        seen_count = 0;
        crc_all    = '0;
        crc_body   = '0;
        ok_lead    = 1'b1;
        ok_tail    = 1'b1;
        lead_byte  = '0;
        soh_ok     = 1'b0;
    endtask

    // Fold one accepted byte into the frame state; on the end byte work out
    // the verdict and return to the empty-frame state.
    task automatic fold_into_frame(input acf_in_t x, output bit done, output acf_out_t v);
        int unsigned idx;
        int unsigned i;
        int unsigned n;
        int unsigned nb;
        int unsigned blen;
        bit          ck;
        bit          hdr;
        bit          ph;
        bit          pr;
        bit          ce;
        bit          pe;
        logic [7:0]  w;
        logic [7:0]  b;
        acf_out_t    r;
        b    = x.payload_byte;
        idx  = seen_count;
        done = 1'b0;
        v    = '0;
        if (idx >= 1)
        begin
            i = idx - 1;
            // the CRC and parity trail the incoming byte through the window
            if (i >= 1)
            begin
                crc_all = kermit_fold(crc_all, recent[0]);
                if (i - 1 >= 8)
                begin
                    crc_body = kermit_fold(crc_body, recent[0]);
                end
            end
            if (i >= 3)
            begin
                if (i - 3 < 8)
                begin
                    ok_lead &= ^recent[2];
                end
                else
                begin
                    ok_tail &= ^recent[2];
                end
            end
            if (i == 0)
            begin
                lead_byte = b;
            end
        end
        else
        begin
            soh_ok = (b == MARKER_SOH);
        end

        if (x.end_of_frame)
        begin
            done = 1'b1;
            r    = '0;
            if (!soh_ok)
            begin
                r.frame_status = ST_NOT_ACARS;
            end
            else if (idx + 1 <= 2)
            begin
                r.frame_status = ST_TOO_SHORT;
            end
            else
            begin
                n    = idx;
                ck   = (n >= 3) && (b == SUFFIX_DEL);
                nb   = ck ? n - 3 : n;
                hdr  = (nb >= 8) && (lead_byte == HEADER_ETX);
                blen = nb - (hdr ? 8 : 0);
                ph   = ok_lead;
                pr   = ok_tail;
                if (ck)
                begin
                    ce = ((hdr ? crc_body : crc_all) != 16'h0000);
                end
                else
                begin
                    // no checksum: the last three bytes are body and still
                    // owe their parity
                    ce = 1'b1;
                    for (int k = 0; k < 3; k++)
                    begin
                        if (n >= k + 1)
                        begin
                            w = (k == 0) ? b : recent[k - 1];
                            if (n - 1 - k < 8)
                            begin
                                ph &= ^w;
                            end
                            else
                            begin
                                pr &= ^w;
                            end
                        end
                    end
                end
                pe = !(pr && (hdr || ph));
                r.crc_error    = ce;
                r.parity_error = pe;
                r.error_count  = {1'b0, ce} + {1'b0, pe};
                r.has_checksum = ck;
                r.has_header   = hdr;
                r.body_length  = (blen > BODY_LEN_MAX) ? 10'(BODY_LEN_MAX) : 10'(blen);
                if (blen + (ck ? CK_CRC_BYTES : 0) > BODY_CAP)
                begin
                    r.frame_status = ST_TOO_LONG;
                end
                else if (blen < MIN_BODY)
                begin
                    r.frame_status = ST_TOO_SHORT;
                end
                else if (drop_shadow && (ce || pe))
                begin
                    r.frame_status = ST_SUPPRESSED;
                end
                else
                begin
                    r.frame_status = ST_ACCEPTED;
                end
            end
            v = r;
            clear_frame_state();
        end
        else
        begin
            recent[2] = recent[1];
            recent[1] = recent[0];
            recent[0] = b;
            if (seen_count < POS_CAP)
            begin
                seen_count++;
            end
        end
    endtask

    // Offer one byte until it transfers, then maybe idle for a burst.
    // A fixed verdict, where given, replaces the running prediction.
    task automatic push_byte(input logic [7:0] b, input logic last,
                             input logic fixed, input acf_out_t want);
        acf_in_t  x;
        bit       done;
        acf_out_t v;
        x.payload_byte = b;
        x.end_of_frame = last;
        byte_data  <= x;
        byte_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (byte_stall);
        bytes_sent++;
        fold_into_frame(x, done, v);
        if (done)
        begin
            verdicts_due.push_back(fixed ? want : v);
        end
        if (!calm && frame_gappy && $urandom_range(0, 3) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic send_frame_buf();
        frame_gappy = ($urandom_range(0, 2) != 0);
        for (int k = 0; k < frame_buf.size(); k++)
        begin
            push_byte(frame_buf[k], k == frame_buf.size() - 1, 1'b0, NO_VERDICT);
        end
    endtask

    // Mostly well-formed frames with random content, some with headers and
    // checksums, plus bursts of noise and damaged frames.
    task automatic compose_random_frame();
        int          kind;
        int          len;
        int          pick;
        bit          hdr;
        bit          ck;
        logic [7:0]  v;
        logic [15:0] c;
        frame_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            // line noise, sometimes opening with the marker
            len = $urandom_range(1, 16);
            for (int k = 0; k < len; k++)
            begin
                frame_buf.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1) == 1)
            begin
                frame_buf[0] = MARKER_SOH;
            end
        end
        else
        begin
            hdr = ($urandom_range(0, 1) == 1);
            ck  = ($urandom_range(0, 3) != 0);
            if (kind == 1)
            begin
                len = $urandom_range(0, 6);
            end
            else if (kind == 2)
            begin
                len = $urandom_range(10, 15);    // around the minimum body
            end
            else
            begin
                len = $urandom_range(13, 40);
            end
            frame_buf.push_back(MARKER_SOH);
            c = '0;
            for (int k = 0; k < (hdr ? HDR_LEN : 0) + len; k++)
            begin
                if (hdr && k == 0)
                begin
                    v = HEADER_ETX;
                end
                else
                begin
                    v = 8'($urandom_range(0, 255));
                    // force odd parity on most bytes
                    if ($urandom_range(0, 15) != 0)
                    begin
                        v[7] = ~(^v[6:0]);
                    end
                end
                frame_buf.push_back(v);
                if (!hdr || k >= HDR_LEN)
                begin
                    c = kermit_fold(c, v);
                end
            end
            if (ck)
            begin
                frame_buf.push_back(c[7:0]);
                frame_buf.push_back(c[15:8]);
                frame_buf.push_back(SUFFIX_DEL);
            end
            if (kind == 3 && frame_buf.size() > 1)
            begin
                // damage one bit somewhere after the marker
                pick = $urandom_range(1, frame_buf.size() - 1);
                frame_buf[pick] = frame_buf[pick] ^ 8'(1 << $urandom_range(0, 7));
            end
        end
    endtask

    // Write the register, then read it back over the same port
    task automatic write_drop_errored(input bit value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= DROP_ADDR;
        pwdata  <= {31'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        drop_shadow = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {31'b0, value})
        begin
            note_mismatch("drop_errored readback", prdata, value);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the byte channel until every verdict is in, let the block settle
    task automatic drain_verdicts();
        int waited;
        waited = 0;
        byte_valid <= 1'b0;
        while (verdicts_due.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_phase(input int budget, input bit with_hold);
        int start;
        bit held;
        start = bytes_sent;
        held  = 1'b0;
        while (bytes_sent - start < budget)
        begin
            if (with_hold && !held && bytes_sent - start > 60)
            begin
                // receiver sits on its stall while frames keep coming
                hold_req = 1'b1;
                held     = 1'b1;
            end
            compose_random_frame();
            send_frame_buf();
        end
    endtask

    // Verdict channel: stall in random bursts, run freely in between,
    // and honour one long hold-off when asked.
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                verdict_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (calm || $urandom_range(0, 2) != 0)
            begin
                verdict_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                verdict_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
    end

    // Compare every transferred verdict with the oldest one due
    always @(posedge clk)
    begin
        acf_out_t want;
        if (rst_n && verdict_valid && !verdict_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                note_mismatch("unexpected verdict, status", verdict_data.frame_status, -1);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (verdict_data.frame_status !== want.frame_status)
                    note_mismatch("frame_status", verdict_data.frame_status, want.frame_status);
                if (verdict_data.crc_error !== want.crc_error)
                    note_mismatch("crc_error", verdict_data.crc_error, want.crc_error);
                if (verdict_data.parity_error !== want.parity_error)
                    note_mismatch("parity_error", verdict_data.parity_error, want.parity_error);
                if (verdict_data.error_count !== want.error_count)
                    note_mismatch("error_count", verdict_data.error_count, want.error_count);
                if (verdict_data.has_checksum !== want.has_checksum)
                    note_mismatch("has_checksum", verdict_data.has_checksum, want.has_checksum);
                if (verdict_data.has_header !== want.has_header)
                    note_mismatch("has_header", verdict_data.has_header, want.has_header);
                if (verdict_data.body_length !== want.body_length)
                    note_mismatch("body_length", verdict_data.body_length, want.body_length);
            end
        end
    end

    // Byte channel and configuration: the run itself
    initial
    begin
        clear_frame_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write the reset value explicitly, then walk the opening table
        write_drop_errored(1'b0);
        frame_gappy = 1'b1;
        foreach (DIRECTED_ROWS[r])
        begin
            push_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].last,
                      DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want);
        end

        // errored frames suppressed; includes the long receiver hold-off
        drain_verdicts();
        write_drop_errored(1'b1);
        random_phase(400, 1'b1);

        // errored frames passed again
        drain_verdicts();
        write_drop_errored(1'b0);
        random_phase(400, 1'b0);

        // last stretch at full rate on both sides
        drain_verdicts();
        write_drop_errored(1'b1);
        calm = 1'b1;
        random_phase(300, 1'b0);

        drain_verdicts();
        repeat (20) @(posedge clk);
        if (verdicts_due.size() != 0)
        begin
            note_mismatch("verdicts still outstanding", 0, verdicts_due.size());
        end
        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
